// ===== rtl/swrl_pkg.sv =====
`timescale 1ns / 1ps

package swrl_pkg;

    localparam int TIME_W    = 48;
    localparam int MS_W      = 22;
    localparam int MAX_W     = 31;
    localparam int BCNT_W    = 7;
    localparam int BKT_W     = 32;
    localparam int DIV_W     = 32;
    localparam int DCNT_W    = 5;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int US_PER_MS = 1000;

    localparam logic [MAX_W-1:0] TOTAL_MAX = {MAX_W{1'b1}};

    typedef enum logic [1:0] {
        REG_WINDOW_MS,
        REG_BUCKET_MS,
        REG_MAX_COUNT,
        REG_BUCKET_COUNT
    } reg_idx_t;

    typedef struct packed {
        logic [MS_W-1:0]   window_ms;
        logic [MS_W-1:0]   bucket_ms;
        logic [MAX_W-1:0]  max_count;
        logic [BCNT_W-1:0] bucket_count;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR_ALL,
        OP_CLR_STEP,
        OP_DIV1_START,
        OP_DIV_STEP,
        OP_DIV1_END,
        OP_DIV2_END,
        OP_SW_RD,
        OP_SW_WR,
        OP_INC_RD,
        OP_INC_WR,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic fetch;
        logic whole;
        logic more;
        logic div_last;
        logic steps_last;
        logic clr_last;
    } dp_status_t;

endpackage

// ===== rtl/swrl_req_if.sv =====
`timescale 1ns / 1ps

interface swrl_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [swrl_pkg::TIME_W-1:0] time_us;

    modport source (output valid, output req_type, output time_us, input ready);
    modport sink (input valid, input req_type, input time_us, output ready);
endinterface

// ===== rtl/swrl_rsp_if.sv =====
`timescale 1ns / 1ps

interface swrl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [swrl_pkg::MAX_W-1:0] window_count;

    modport source (output valid, output status, output window_count, input ready);
    modport sink (input valid, input status, input window_count, output ready);
endinterface

// ===== rtl/swrl_cfg.sv =====
`timescale 1ns / 1ps

module swrl_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swrl_pkg::PADDR_W-1:0]  paddr,
    input  logic [swrl_pkg::PDATA_W-1:0]  pwdata,
    output logic [swrl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output swrl_pkg::cfg_t                cfg
);
    import swrl_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t sel;
    logic     wr_en;

    assign sel    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms    <= '0;
            cfg_reg.bucket_ms    <= '0;
            cfg_reg.max_count    <= '0;
            cfg_reg.bucket_count <= BCNT_W'(1);
        end
        else if (wr_en)
        begin
            case (sel)
                REG_WINDOW_MS:    cfg_reg.window_ms    <= pwdata[MS_W-1:0];
                REG_BUCKET_MS:    cfg_reg.bucket_ms    <= pwdata[MS_W-1:0];
                REG_MAX_COUNT:    cfg_reg.max_count    <= pwdata[MAX_W-1:0];
                REG_BUCKET_COUNT: cfg_reg.bucket_count <= pwdata[BCNT_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_WINDOW_MS:    prdata = PDATA_W'(cfg_reg.window_ms);
            REG_BUCKET_MS:    prdata = PDATA_W'(cfg_reg.bucket_ms);
            REG_MAX_COUNT:    prdata = PDATA_W'(cfg_reg.max_count);
            REG_BUCKET_COUNT: prdata = PDATA_W'(cfg_reg.bucket_count);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/swrl_ctrl.sv =====
`timescale 1ns / 1ps

module swrl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  swrl_pkg::dp_status_t st,
    output swrl_pkg::cmd_t       cmd
);
    import swrl_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_CLR,
        S_DIV1,
        S_DIV1_END,
        S_DIV2,
        S_DIV2_END,
        S_SW_RD,
        S_SW_WR,
        S_COUNT,
        S_INC_WR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_INIT:
            begin
                // clearing pass over the bucket memory after reset
                cmd.op = OP_CLR_STEP;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!st.enabled)
                    state_next = S_DONE;
                else if (st.whole)
                begin
                    cmd.op     = OP_CLR_ALL;
                    state_next = S_CLR;
                end
                else if (st.more)
                begin
                    cmd.op     = OP_DIV1_START;
                    state_next = S_DIV1;
                end
                else
                    state_next = S_COUNT;
            end
            S_CLR:
            begin
                cmd.op = OP_CLR_STEP;
                if (st.clr_last)
                    state_next = S_COUNT;
            end
            S_DIV1:
            begin
                cmd.op = OP_DIV_STEP;
                if (st.div_last)
                    state_next = S_DIV1_END;
            end
            S_DIV1_END:
            begin
                cmd.op     = OP_DIV1_END;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.op = OP_DIV_STEP;
                if (st.div_last)
                    state_next = S_DIV2_END;
            end
            S_DIV2_END:
            begin
                cmd.op     = OP_DIV2_END;
                state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                cmd.op     = OP_SW_RD;
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                cmd.op = OP_SW_WR;
                if (st.steps_last)
                    state_next = S_COUNT;
                else
                    state_next = S_SW_RD;
            end
            S_COUNT:
            begin
                if (st.fetch)
                    state_next = S_DONE;
                else
                begin
                    cmd.op     = OP_INC_RD;
                    state_next = S_INC_WR;
                end
            end
            S_INC_WR:
            begin
                cmd.op     = OP_INC_WR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // output register free or being drained this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || (cmd.op == OP_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |=> out_valid_reg)
        else $error("result beat not presented after load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> cmd.op != OP_OUT)
        else $error("pending result beat overwritten");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |=> !in_ready)
        else $error("second item taken while busy");

endmodule

// ===== rtl/swrl_dp.sv =====
`timescale 1ns / 1ps

module swrl_dp #(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  swrl_pkg::cfg_t               cfg,
    input  swrl_pkg::cmd_t               cmd,
    input  logic                         req_type,
    input  logic [swrl_pkg::TIME_W-1:0]  time_us,
    output swrl_pkg::dp_status_t         st,
    output logic                         status,
    output logic [swrl_pkg::MAX_W-1:0]   window_count
);
    import swrl_pkg::*;

    localparam int IW = $clog2(MAX_BUCKETS);

    // bucket memory, one write and one read port
    logic [BKT_W-1:0]  bucket_mem_reg [MAX_BUCKETS];
    logic [BKT_W-1:0]  rdata_reg;

    // per-item working registers
    logic              fetch_reg;
    logic              enabled_reg;
    logic [TIME_W-1:0] now_reg;
    logic [DIV_W-1:0]  win_us_reg;
    logic [DIV_W-1:0]  bkt_us_reg;
    logic [BCNT_W-1:0] nb_reg;
    logic [BCNT_W-1:0] steps_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  divisor_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              out_status_reg;
    logic [MAX_W-1:0]  out_count_reg;

    // limiter state
    logic [MAX_W-1:0]  total_reg;
    logic [MAX_W-1:0]  total_next;
    logic [IW-1:0]     cur_reg;
    logic [IW-1:0]     cur_next;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     idx_next;

    logic [BCNT_W-1:0] nb_cfg;
    logic              enabled_cfg;
    logic [TIME_W-1:0] elapsed;
    logic [DIV_W:0]    trial;
    logic              trial_ge;
    logic [DIV_W-1:0]  rem_step;
    logic [IW-1:0]     idx_inc;
    logic [IW-1:0]     cur_inc;
    logic [DIV_W-1:0]  cur_sum;
    logic [DIV_W-1:0]  cur_wrap;
    logic [MAX_W-1:0]  total_sub;
    logic [MAX_W-1:0]  total_inc;
    logic [BKT_W-1:0]  bucket_inc;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [BKT_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;

    always_comb
    begin
        if (cfg.bucket_count == '0)
            nb_cfg = BCNT_W'(1);
        else if (32'(cfg.bucket_count) > MAX_BUCKETS)
            nb_cfg = BCNT_W'(MAX_BUCKETS);
        else
            nb_cfg = cfg.bucket_count;
    end

    assign enabled_cfg = (cfg.window_ms != '0) && (cfg.bucket_ms != '0);

    assign elapsed  = now_reg - last_reg;
    assign st.whole = (now_reg < last_reg) || (elapsed >= TIME_W'(win_us_reg));
    assign st.more  = elapsed > TIME_W'(bkt_us_reg);
    assign st.enabled    = enabled_reg;
    assign st.fetch      = fetch_reg;
    assign st.div_last   = (dcnt_reg == {DCNT_W{1'b1}});
    assign st.steps_last = (steps_reg == BCNT_W'(1));
    assign st.clr_last   = (32'(idx_reg) == MAX_BUCKETS - 1);

    // restoring divider, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, divisor_reg};
    assign rem_step = trial_ge ? DIV_W'(trial - {1'b0, divisor_reg}) : trial[DIV_W-1:0];

    // ring steps wrap at the bucket count in use
    assign idx_inc  = (32'(idx_reg) + 1 == 32'(nb_reg)) ? '0 : idx_reg + 1'b1;
    assign cur_inc  = (32'(cur_reg) + 1 == 32'(nb_reg)) ? '0 : cur_reg + 1'b1;
    assign cur_sum  = DIV_W'(cur_reg) + rem_reg;
    assign cur_wrap = (cur_sum >= DIV_W'(nb_reg)) ? cur_sum - DIV_W'(nb_reg) : cur_sum;

    assign total_sub  = ({1'b0, total_reg} > rdata_reg) ?
                        total_reg - rdata_reg[MAX_W-1:0] : '0;
    assign total_inc  = (total_reg == TOTAL_MAX) ? total_reg : total_reg + 1'b1;
    assign bucket_inc = (rdata_reg == {BKT_W{1'b1}}) ? rdata_reg : rdata_reg + 1'b1;

    always_comb
    begin
        total_next = total_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                if (enabled_cfg && (32'(cur_reg) >= 32'(nb_cfg)))
                    cur_next = '0;
            end
            OP_CLR_ALL:
            begin
                total_next = '0;
                cur_next   = '0;
                last_next  = now_reg;
                idx_next   = '0;
            end
            OP_CLR_STEP:
                idx_next = idx_reg + 1'b1;
            OP_DIV1_END:
            begin
                // boundary moves by whole spans: now minus the leftover
                last_next = now_reg - TIME_W'(rem_reg);
                idx_next  = cur_inc;
            end
            OP_DIV2_END:
                cur_next = IW'(cur_wrap);
            OP_SW_WR:
            begin
                total_next = total_sub;
                idx_next   = idx_inc;
            end
            OP_INC_RD:
                total_next = total_inc;
            default:
                total_next = total_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            cur_reg   <= '0;
            last_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            cur_reg   <= cur_next;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                fetch_reg   <= req_type;
                now_reg     <= time_us;
                enabled_reg <= enabled_cfg;
                nb_reg      <= nb_cfg;
                win_us_reg  <= DIV_W'(DIV_W'(cfg.window_ms) * DIV_W'(US_PER_MS));
                bkt_us_reg  <= DIV_W'(DIV_W'(cfg.bucket_ms) * DIV_W'(US_PER_MS));
            end
            OP_DIV1_START:
            begin
                rem_reg     <= '0;
                quo_reg     <= elapsed[DIV_W-1:0];
                divisor_reg <= bkt_us_reg;
                dcnt_reg    <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg  <= rem_step;
                quo_reg  <= {quo_reg[DIV_W-2:0], trial_ge};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            OP_DIV1_END:
            begin
                // quotient is the span count; reduce it modulo the ring next
                steps_reg   <= (quo_reg >= DIV_W'(nb_reg)) ? nb_reg : quo_reg[BCNT_W-1:0];
                rem_reg     <= '0;
                divisor_reg <= DIV_W'(nb_reg);
                dcnt_reg    <= '0;
            end
            OP_SW_WR:
                steps_reg <= steps_reg - 1'b1;
            OP_OUT:
            begin
                out_status_reg <= enabled_reg && !fetch_reg && (cfg.max_count != '0)
                                  && (total_reg > cfg.max_count);
                out_count_reg  <= total_reg;
            end
            default:
                out_count_reg <= out_count_reg;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = idx_reg;
        case (cmd.op)
            OP_CLR_STEP:
                mem_we = 1'b1;
            OP_SW_RD:
                mem_re = 1'b1;
            OP_SW_WR:
                mem_we = 1'b1;
            OP_INC_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = cur_reg;
            end
            OP_INC_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = bucket_inc;
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            bucket_mem_reg[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= bucket_mem_reg[mem_raddr];
    end

    assign status       = out_status_reg;
    assign window_count = out_count_reg;

    a_sub_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SW_WR |=> total_reg <= $past(total_reg))
        else $error("window total grew while expiring a bucket");

    a_cur_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_DIV2_END |=> 32'(cur_reg) < 32'(nb_reg))
        else $error("current bucket left the ring");

    a_inc_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INC_RD |=>
            (total_reg == $past(total_reg) + 1'b1) || (total_reg == TOTAL_MAX))
        else $error("window total count step wrong");

endmodule

// ===== rtl/sliding_window_rate_limiter_top.sv =====
// Sliding-window request limiter: each request beat carries a microsecond timestamp and a
// type (check counts one request, fetch only advances the window), and every request gives
// exactly one result beat with the full flag and the window count. The user must write the
// configuration over the APB port at byte addresses 0, 4, 8 and 12 (window_ms, bucket_ms,
// max_count, bucket_count) only while the block is idle; the block does not enforce this.
// Bucket counters live in a memory of MAX_BUCKETS words with one write and one read port,
// and a radix-2 divider is run twice per bucket advance (span count, then ring position).
// With limiting off a request goes straight to its result. When the whole window has gone
// by, all MAX_BUCKETS words are cleared first; when buckets expire, each expired bucket, at
// most the bucket count in use, is read, taken off the total and cleared after both
// divisions. A stalled result beat holds up later results. After reset the bucket memory
// is cleared one word a cycle, all MAX_BUCKETS words, before the first request is taken. A
// finished result sits in an output register, so the next request is taken while it waits.
`timescale 1ns / 1ps

module sliding_window_rate_limiter_top #(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    swrl_req_if.sink                      req,
    swrl_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swrl_pkg::PADDR_W-1:0]  paddr,
    input  logic [swrl_pkg::PDATA_W-1:0]  pwdata,
    output logic [swrl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import swrl_pkg::*;

    cfg_t       cfg;
    cmd_t       cmd;
    dp_status_t st;
    logic       in_ready;
    logic       out_valid;

    swrl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    swrl_dp #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .time_us      (req.time_us),
        .st           (st),
        .status       (rsp.status),
        .window_count (rsp.window_count)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

// ===== tb/sliding_window_rate_limiter_top_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_rate_limiter_top_tb;

    import swrl_pkg::*;

    localparam int NBKT_MAX   = 64;
    localparam int PHASE_ITEMS = 262;
    localparam int HOLD_AT    = 100;
    localparam int HOLD_LEN   = 400;
    localparam int TAIL_WAIT  = 120;
    localparam int CYCLE_LIMIT = 2000000;

    localparam logic REQ_CHECK = 1'b0;
    localparam logic REQ_FETCH = 1'b1;
    localparam logic ST_NORMAL = 1'b0;
    localparam logic ST_FULL   = 1'b1;

    typedef struct packed {
        logic             status;
        logic [MAX_W-1:0] count;
    } win_result_t;

    typedef struct {
        logic              cfg_row;
        reg_idx_t          ra;
        logic [31:0]       value;
        logic              fetch;
        logic [TIME_W-1:0] t;
        logic              known;
        win_result_t       res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    swrl_req_if req_ch ();
    swrl_rsp_if rsp_ch ();

    sliding_window_rate_limiter_top #(
        .MAX_BUCKETS(NBKT_MAX)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the limiter state and registers
    logic [MS_W-1:0]   m_window_ms = '0;
    logic [MS_W-1:0]   m_bucket_ms = '0;
    logic [MAX_W-1:0]  m_max_count = '0;
    logic [BCNT_W-1:0] m_nbkt      = 7'd1;
    logic [31:0]       bkt_cnt [NBKT_MAX];
    logic [31:0]       win_total = '0;
    int unsigned       cur_bkt = 0;
    logic [TIME_W-1:0] boundary_us = '0;

    win_result_t pending_results [$];
    stim_row_t   directed_rows [$];

    int unsigned src_idle = 0;
    int unsigned snk_idle = 0;
    logic        hold_go = 1'b0;
    int          errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_fetch = 0;
    int unsigned n_full = 0;
    int unsigned n_settings = 0;
    int unsigned cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic win_result_t limiter_step(input logic fetch, input logic [TIME_W-1:0] now);
        longint unsigned win_us;
        longint unsigned bkt_us;
        longint unsigned elapsed;
        longint unsigned n;
        longint unsigned steps;
        int unsigned     nb;
        int unsigned     idx;
        win_result_t     r;
        r.status = ST_NORMAL;
        if (m_window_ms != 0 && m_bucket_ms != 0)
        begin
            nb = (m_nbkt == 0) ? 1 : (m_nbkt > NBKT_MAX) ? NBKT_MAX : m_nbkt;
            if (cur_bkt >= nb)
                cur_bkt = 0;
            win_us  = 64'(m_window_ms) * 64'd1000;
            bkt_us  = 64'(m_bucket_ms) * 64'd1000;
            elapsed = 64'(now) - 64'(boundary_us);
            if (now < boundary_us || elapsed >= win_us)
            begin
                foreach (bkt_cnt[i])
                    bkt_cnt[i] = '0;
                win_total   = '0;
                cur_bkt     = 0;
                boundary_us = now;
            end
            else if (elapsed > bkt_us)
            begin
                n = elapsed / bkt_us;
                steps = (n < nb) ? n : nb;
                for (int unsigned i = 0; i < steps; i++)
                begin
                    idx = (cur_bkt + 1 + i) % nb;
                    win_total = (win_total > bkt_cnt[idx]) ? win_total - bkt_cnt[idx] : '0;
                    bkt_cnt[idx] = '0;
                end
                cur_bkt = int'((64'(cur_bkt) + n) % nb);
                boundary_us = boundary_us + 48'(n * bkt_us);
            end
            if (fetch == REQ_CHECK)
            begin
                if (win_total < 32'(TOTAL_MAX))
                    win_total++;
                if (bkt_cnt[cur_bkt] != 32'hFFFF_FFFF)
                    bkt_cnt[cur_bkt]++;
                if (m_max_count != 0 && win_total > 32'(m_max_count))
                    r.status = ST_FULL;
            end
        end
        r.count = (win_total > 32'(TOTAL_MAX)) ? TOTAL_MAX : win_total[MAX_W-1:0];
        return r;
    endfunction

    function automatic longint unsigned rand_below(input longint unsigned hi);
        if (hi == 0)
            return 0;
        return {$urandom, $urandom} % hi;
    endfunction

    // mostly small steps in a bucket; jumps over buckets or window, back, or anywhere
    function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
        longint unsigned bkt;
        longint unsigned win;
        longint unsigned v;
        int unsigned     sel;
        bkt = (m_bucket_ms == 0) ? 64'd1000 : 64'(m_bucket_ms) * 64'd1000;
        win = (m_window_ms == 0) ? 64'd10000 : 64'(m_window_ms) * 64'd1000;
        sel = $urandom_range(99);
        v = 64'(t);
        if (sel < 55)
            v = v + rand_below(bkt / 2 + 1);
        else if (sel < 85)
            v = v + rand_below(win);
        else if (sel < 92)
            v = v + win + rand_below(win);
        else if (sel < 96)
            v = v - rand_below(bkt) - 1;
        else
            v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic void add_item(input logic fetch, input logic [TIME_W-1:0] t,
                                     input logic known, input logic st, input int cnt);
        stim_row_t row;
        row.cfg_row = 1'b0;
        row.ra = REG_WINDOW_MS;
        row.value = '0;
        row.fetch = fetch;
        row.t = t;
        row.known = known;
        row.res.status = st;
        row.res.count = MAX_W'(cnt);
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_cfg(input reg_idx_t ra, input logic [31:0] value);
        stim_row_t row;
        row.cfg_row = 1'b1;
        row.ra = ra;
        row.value = value;
        row.fetch = REQ_CHECK;
        row.t = '0;
        row.known = 1'b0;
        row.res = '0;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic write_reg(input reg_idx_t ra, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ra, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (ra)
            REG_WINDOW_MS:    m_window_ms = value[MS_W-1:0];
            REG_BUCKET_MS:    m_bucket_ms = value[MS_W-1:0];
            REG_MAX_COUNT:    m_max_count = value[MAX_W-1:0];
            REG_BUCKET_COUNT: m_nbkt      = value[BCNT_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic send_req(input logic fetch, input logic [TIME_W-1:0] now,
                            input logic known, input win_result_t typed);
        win_result_t predicted;
        while ($urandom_range(99) < src_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= fetch;
        req_ch.time_us  <= now;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = limiter_step(fetch, now);
        if (known)
            predicted = typed;
        pending_results = {pending_results, predicted};
        n_sent++;
        if (fetch == REQ_FETCH)
            n_fetch++;
        if (n_sent == directed_rows.size() + HOLD_AT)
            hold_go = 1'b1;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
            $display("[sliding_window_rate_limiter_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        win_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, got status %0d count %0d",
                         $time, rsp_ch.status, rsp_ch.window_count);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.window_count !== want.count)
                begin
                    $display("%0t: window_count mismatch: expected %0d, got %0d",
                             $time, want.count, rsp_ch.window_count);
                    errors++;
                end
                if (rsp_ch.status === ST_FULL)
                    n_full++;
            end
        end
    end

    // result side: random stalls plus one long hold-off to back the block up
    initial
    begin : sink_side
        int unsigned hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left != 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial
    begin : stimulus
        cfg_t              settings [7];
        cfg_t              cs;
        logic [TIME_W-1:0] cursor;
        int unsigned       mode;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_CHECK;
        req_ch.time_us = '0;
        foreach (bkt_cnt[i])
            bkt_cnt[i] = '0;

        // disabled after reset
        add_item(REQ_CHECK, 48'd0, 1'b1, ST_NORMAL, 0);
        add_item(REQ_CHECK, 48'hFFFF_FFFF_FFFF, 1'b1, ST_NORMAL, 0);
        add_item(REQ_FETCH, 48'd5, 1'b1, ST_NORMAL, 0);
        // window set but bucket span still zero: still disabled
        add_cfg(REG_WINDOW_MS, 32'd4);
        add_item(REQ_CHECK, 48'd100, 1'b1, ST_NORMAL, 0);
        add_cfg(REG_BUCKET_MS, 32'd1);
        add_cfg(REG_MAX_COUNT, 32'd2);
        add_cfg(REG_BUCKET_COUNT, 32'd4);
        add_item(REQ_CHECK, 48'd1000, 1'b1, ST_NORMAL, 1);
        add_item(REQ_CHECK, 48'd1200, 1'b1, ST_NORMAL, 2);
        add_item(REQ_CHECK, 48'd1300, 1'b1, ST_FULL, 3);
        add_item(REQ_FETCH, 48'd1400, 1'b1, ST_NORMAL, 3);
        add_item(REQ_CHECK, 48'd2500, 1'b0, ST_NORMAL, 0);
        add_item(REQ_FETCH, 48'd4100, 1'b0, ST_NORMAL, 0);
        add_item(REQ_CHECK, 48'd9000, 1'b0, ST_NORMAL, 0);
        // time going backward clears the window
        add_item(REQ_CHECK, 48'd8000, 1'b0, ST_NORMAL, 0);
        add_item(REQ_FETCH, 48'd0, 1'b1, ST_NORMAL, 0);
        add_cfg(REG_WINDOW_MS, 32'd10);
        add_cfg(REG_BUCKET_COUNT, 32'd10);
        add_item(REQ_CHECK, 48'd7500, 1'b0, ST_NORMAL, 0);
        // shrink the ring under the current bucket
        add_cfg(REG_BUCKET_COUNT, 32'd4);
        add_item(REQ_CHECK, 48'd7600, 1'b0, ST_NORMAL, 0);
        add_cfg(REG_BUCKET_COUNT, 32'd0);
        add_item(REQ_CHECK, 48'd9700, 1'b0, ST_NORMAL, 0);
        add_cfg(REG_WINDOW_MS, 32'd2147483);
        add_cfg(REG_BUCKET_MS, 32'd1000);
        add_cfg(REG_MAX_COUNT, 32'd2147483647);
        add_cfg(REG_BUCKET_COUNT, 32'd127);
        add_item(REQ_CHECK, 48'hFFFF_FFFF_FFFF, 1'b0, ST_NORMAL, 0);
        add_item(REQ_FETCH, 48'd0, 1'b1, ST_NORMAL, 0);
        add_item(REQ_CHECK, 48'd63500000, 1'b0, ST_NORMAL, 0);
        add_item(REQ_CHECK, 48'd63500001, 1'b0, ST_NORMAL, 0);
        add_cfg(REG_MAX_COUNT, 32'd0);
        add_item(REQ_CHECK, 48'd63600000, 1'b0, ST_NORMAL, 0);
        // disabled again: total is held
        add_cfg(REG_WINDOW_MS, 32'd0);
        add_item(REQ_FETCH, 48'd1, 1'b0, ST_NORMAL, 0);
        add_cfg(REG_WINDOW_MS, 32'd2147483);
        add_cfg(REG_BUCKET_MS, 32'd2147483);
        add_item(REQ_CHECK, 48'h8000_0000_0000, 1'b0, ST_NORMAL, 0);
        add_item(REQ_CHECK, 48'h8000_7FFF_FB18, 1'b0, ST_NORMAL, 0);

        settings[0] = '{22'd10, 22'd1, 31'd7, 7'd10};
        settings[1] = '{22'd64, 22'd1, 31'd0, 7'd64};
        settings[2] = '{22'd7, 22'd2, 31'd1, 7'd4};
        settings[3] = '{22'd2147483, 22'd2147483, 31'd2147483647, 7'd1};
        settings[4] = '{22'd2147483, 22'd33554, 31'd40, 7'd64};
        settings[5] = '{22'd5, 22'd1, 31'd3, 7'd127};
        settings[6].window_ms = MS_W'($urandom_range(50, 1));
        settings[6].bucket_ms = MS_W'($urandom_range(32'(settings[6].window_ms), 1));
        settings[6].bucket_count = BCNT_W'(settings[6].window_ms / settings[6].bucket_ms + 1'b1);
        settings[6].max_count = MAX_W'($urandom_range(20, 0));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle = 32;
        snk_idle = 46;
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].cfg_row)
            begin
                settle();
                write_reg(directed_rows[k].ra, directed_rows[k].value);
            end
            else
                send_req(directed_rows[k].fetch, directed_rows[k].t,
                         directed_rows[k].known, directed_rows[k].res);
        end

        cursor = TIME_W'({$urandom, $urandom});
        for (int p = 0; p < 7; p++)
        begin
            mode = (p * 3) / 7;
            src_idle = (mode == 0) ? 32 : (mode == 1) ? 46 : 0;
            snk_idle = (mode == 0) ? 46 : (mode == 1) ? 32 : 0;
            cs = settings[p];
            settle();
            write_reg(REG_WINDOW_MS, 32'(cs.window_ms));
            write_reg(REG_BUCKET_MS, 32'(cs.bucket_ms));
            write_reg(REG_MAX_COUNT, 32'(cs.max_count));
            write_reg(REG_BUCKET_COUNT, 32'(cs.bucket_count));
            n_settings++;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                cursor = next_time(cursor);
                send_req(($urandom_range(3) == 0) ? REQ_FETCH : REQ_CHECK, cursor, 1'b0, '0);
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("run covered %0d requests (%0d fetches), %0d full results, %0d random settings",
                 n_sent, n_fetch, n_full, n_settings);
        $display("directed rows included disabled, backward time, ring shrink and extreme spans");
        if (errors == 0)
            $display("[sliding_window_rate_limiter_top] OK");
        else
            $display("[sliding_window_rate_limiter_top] ERROR");
        $finish;
    end

endmodule
